/* rtl/core/blx_pkg.sv */
package blx_pkg;

	// Identifier bytes kept per token (1..8)
	localparam logic [3:0] MAX_ID_CHARS = 4'd8;

	// Output token queue
	localparam int TQ_DEPTH = 4;
	localparam int TQ_AW    = $clog2(TQ_DEPTH);
	localparam int TQ_CW    = $clog2(TQ_DEPTH + 1);

	// Token kinds
	localparam logic [4:0] KIND_NUM    = 5'd0;
	localparam logic [4:0] KIND_ID     = 5'd1;
	localparam logic [4:0] KIND_INPUT  = 5'd2;
	localparam logic [4:0] KIND_LET    = 5'd3;
	localparam logic [4:0] KIND_PRINT  = 5'd4;
	localparam logic [4:0] KIND_GOTO   = 5'd5;
	localparam logic [4:0] KIND_IF     = 5'd6;
	localparam logic [4:0] KIND_LPAREN = 5'd7;
	localparam logic [4:0] KIND_RPAREN = 5'd8;
	localparam logic [4:0] KIND_SEMI   = 5'd9;
	localparam logic [4:0] KIND_COLON  = 5'd10;
	localparam logic [4:0] KIND_PLUS   = 5'd11;
	localparam logic [4:0] KIND_MINUS  = 5'd12;
	localparam logic [4:0] KIND_UMINUS = 5'd13;
	localparam logic [4:0] KIND_MUL    = 5'd14;
	localparam logic [4:0] KIND_DIV    = 5'd15;
	localparam logic [4:0] KIND_ASSIGN = 5'd16;
	localparam logic [4:0] KIND_RELOP  = 5'd17;
	localparam logic [4:0] KIND_END    = 5'd18;
	localparam logic [4:0] KIND_START  = 5'd19;

	// Relation codes
	localparam logic [2:0] REL_LT = 3'd0;
	localparam logic [2:0] REL_LE = 3'd1;
	localparam logic [2:0] REL_EQ = 3'd2;
	localparam logic [2:0] REL_NE = 3'd3;
	localparam logic [2:0] REL_GT = 3'd4;
	localparam logic [2:0] REL_GE = 3'd5;

	localparam logic [30:0] NUM_MAX  = 31'h7FFF_FFFF;
	localparam logic [15:0] LINE_MAX = 16'hFFFF;

	// Keyword text, first character in the low byte, zero padded
	localparam logic [63:0] KW_INPUT = 64'h0000_0074_7570_6E69;
	localparam logic [63:0] KW_LET   = 64'h0000_0000_0074_656C;
	localparam logic [63:0] KW_PRINT = 64'h0000_0074_6E69_7270;
	localparam logic [63:0] KW_GOTO  = 64'h0000_0000_6F74_6F67;
	localparam logic [63:0] KW_IF    = 64'h0000_0000_0000_6669;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_NUM  = 3'd1,
		MODE_ID   = 3'd2,
		MODE_LT   = 3'd3,
		MODE_EQ   = 3'd4,
		MODE_GT   = 3'd5
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_input;
	} blx_in_t;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [2:0]  relop_kind;
		logic [30:0] number_value;
		logic        number_overflow;
		logic [63:0] ident_chars;
		logic [3:0]  ident_length;
		logic        ident_truncated;
		logic [15:0] line_number;
		logic        last;
	} blx_out_t;

	// Tokens produced by one accepted character
	typedef struct packed {
		logic [1:0] count;
		blx_out_t   t0;
		blx_out_t   t1;
	} scan_res_t;

endpackage

/* rtl/core/blx_scan.sv */
module blx_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  blx_pkg::blx_in_t  src,
	output blx_pkg::scan_res_t res
);
	import blx_pkg::*;

	scan_mode_t  mode_q, mode_d;
	logic [30:0] num_q, num_d;
	logic        sat_q, sat_d;
	logic [63:0] idb_q, idb_d;
	logic [3:0]  idc_q, idc_d;
	logic        idl_q, idl_d;
	logic [15:0] line_q, line_d;
	logic [4:0]  prev_q, prev_d;

	function automatic logic [4:0] kw_kind(input logic [63:0] b, input logic [3:0] n,
		input logic lng);
		logic [4:0] k;
		k = KIND_ID;
		if (!lng) begin
			if (n == 4'd5 && b == KW_INPUT)      k = KIND_INPUT;
			else if (n == 4'd3 && b == KW_LET)   k = KIND_LET;
			else if (n == 4'd5 && b == KW_PRINT) k = KIND_PRINT;
			else if (n == 4'd4 && b == KW_GOTO)  k = KIND_GOTO;
			else if (n == 4'd2 && b == KW_IF)    k = KIND_IF;
		end
		return k;
	endfunction

	logic [7:0]  c;
	logic        is_dig, is_alp, is_nl;
	logic [34:0] num_ext;
	logic        fl_v, id_v, id_nl;
	blx_out_t    blank_tok, fl_tok, id_tok, t0, t1;
	logic [4:0]  p, kw;
	scan_mode_t  id_mode;
	logic [1:0]  n;

	always_comb begin
		c      = src.ch;
		is_dig = (c >= "0") && (c <= "9");
		is_alp = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
		is_nl  = (c == 8'h0A);
		// accum * 10 + digit
		num_ext = ({4'd0, num_q} << 3) + ({4'd0, num_q} << 1) + {31'd0, c[3:0]};

		blank_tok             = '0;
		blank_tok.line_number = line_q;

		// pending token
		fl_v   = 1'b0;
		fl_tok = blank_tok;
		kw     = kw_kind(idb_q, idc_q, idl_q);
		unique case (mode_q)
			MODE_NUM: begin
				fl_v                   = 1'b1;
				fl_tok.token_kind      = KIND_NUM;
				fl_tok.number_value    = num_q;
				fl_tok.number_overflow = sat_q;
			end
			MODE_ID: begin
				fl_v              = 1'b1;
				fl_tok.token_kind = kw;
				if (kw == KIND_ID) begin
					fl_tok.ident_chars     = idb_q;
					fl_tok.ident_length    = idc_q;
					fl_tok.ident_truncated = idl_q;
				end
			end
			MODE_LT: begin
				fl_v              = 1'b1;
				fl_tok.token_kind = KIND_RELOP;
				fl_tok.relop_kind = REL_LT;
			end
			MODE_GT: begin
				fl_v              = 1'b1;
				fl_tok.token_kind = KIND_RELOP;
				fl_tok.relop_kind = REL_GT;
			end
			MODE_EQ: begin
				fl_v              = 1'b1;
				fl_tok.token_kind = KIND_ASSIGN;
			end
			default: fl_v = 1'b0;
		endcase

		// character scanned from idle, after any pending token went out
		p       = fl_v ? fl_tok.token_kind : prev_q;
		id_v    = 1'b0;
		id_nl   = 1'b0;
		id_mode = MODE_IDLE;
		id_tok  = blank_tok;
		priority if (c == 8'h20 || c == 8'h09 || is_nl) begin
			id_nl = is_nl;
		end else if (is_dig) begin
			id_mode = MODE_NUM;
		end else if (is_alp) begin
			id_mode = MODE_ID;
		end else if (c == "<") begin
			id_mode = MODE_LT;
		end else if (c == ">") begin
			id_mode = MODE_GT;
		end else if (c == "=") begin
			id_mode = MODE_EQ;
		end else if (c == "+") begin
			id_v = 1'b1; id_tok.token_kind = KIND_PLUS;
		end else if (c == "-") begin
			id_v = 1'b1;
			if (p == KIND_PLUS || p == KIND_MINUS || p == KIND_UMINUS || p == KIND_MUL ||
				p == KIND_DIV || p == KIND_ASSIGN || p == KIND_LPAREN ||
				p == KIND_RELOP || p == KIND_START) begin
				id_tok.token_kind = KIND_UMINUS;
			end else begin
				id_tok.token_kind = KIND_MINUS;
			end
		end else if (c == "*") begin
			id_v = 1'b1; id_tok.token_kind = KIND_MUL;
		end else if (c == "/") begin
			id_v = 1'b1; id_tok.token_kind = KIND_DIV;
		end else if (c == "(") begin
			id_v = 1'b1; id_tok.token_kind = KIND_LPAREN;
		end else if (c == ")") begin
			id_v = 1'b1; id_tok.token_kind = KIND_RPAREN;
		end else if (c == ";") begin
			id_v = 1'b1; id_tok.token_kind = KIND_SEMI;
		end else if (c == ":") begin
			id_v = 1'b1; id_tok.token_kind = KIND_COLON;
		end else begin
			id_v = 1'b0; // unknown byte, dropped
		end

		mode_d = mode_q;
		num_d  = num_q;
		sat_d  = sat_q;
		idb_d  = idb_q;
		idc_d  = idc_q;
		idl_d  = idl_q;
		line_d = line_q;
		prev_d = prev_q;
		n      = 2'd0;
		t0     = blank_tok;
		t1     = blank_tok;

		priority if (src.end_of_input) begin
			if (fl_v) begin
				n                = 2'd2;
				t0               = fl_tok;
				t1.token_kind    = KIND_END;
			end else begin
				n                = 2'd1;
				t0.token_kind    = KIND_END;
			end
			mode_d = MODE_IDLE;
			line_d = 16'd1;
			prev_d = KIND_START;
		end else if (mode_q == MODE_NUM && is_dig) begin
			if (num_ext > {4'd0, NUM_MAX}) begin
				num_d = NUM_MAX;
				sat_d = 1'b1;
			end else begin
				num_d = num_ext[30:0];
			end
		end else if (mode_q == MODE_ID && (is_alp || is_dig)) begin
			if (idc_q < MAX_ID_CHARS) begin
				idb_d = idb_q | ({56'd0, c} << {idc_q[2:0], 3'b000});
				idc_d = idc_q + 4'd1;
			end else begin
				idl_d = 1'b1;
			end
		end else if ((mode_q == MODE_LT && (c == ">" || c == "=")) ||
			((mode_q == MODE_GT || mode_q == MODE_EQ) && c == "=")) begin
			n             = 2'd1;
			t0.token_kind = KIND_RELOP;
			if (mode_q == MODE_LT)      t0.relop_kind = (c == ">") ? REL_NE : REL_LE;
			else if (mode_q == MODE_GT) t0.relop_kind = REL_GE;
			else                        t0.relop_kind = REL_EQ;
			mode_d = MODE_IDLE;
			prev_d = KIND_RELOP;
		end else begin
			mode_d = id_mode;
			if (fl_v && id_v) begin
				n  = 2'd2;
				t0 = fl_tok;
				t1 = id_tok;
			end else if (fl_v) begin
				n  = 2'd1;
				t0 = fl_tok;
			end else if (id_v) begin
				n  = 2'd1;
				t0 = id_tok;
			end
			if (id_v)      prev_d = id_tok.token_kind;
			else if (fl_v) prev_d = fl_tok.token_kind;
			if (id_nl && line_q != LINE_MAX) line_d = line_q + 16'd1;
			if (id_mode == MODE_NUM) begin
				num_d = {27'd0, c[3:0]};
				sat_d = 1'b0;
			end
			if (id_mode == MODE_ID) begin
				idb_d = {56'd0, c};
				idc_d = 4'd1;
				idl_d = 1'b0;
			end
		end

		t0.last   = (n == 2'd1);
		t1.last   = 1'b1;
		res.count = n;
		res.t0    = t0;
		res.t1    = t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			num_q  <= '0;
			sat_q  <= 1'b0;
			idb_q  <= '0;
			idc_q  <= '0;
			idl_q  <= 1'b0;
			line_q <= 16'd1;
			prev_q <= KIND_START;
		end else if (step) begin
			mode_q <= mode_d;
			num_q  <= num_d;
			sat_q  <= sat_d;
			idb_q  <= idb_d;
			idc_q  <= idc_d;
			idl_q  <= idl_d;
			line_q <= line_d;
			prev_q <= prev_d;
		end
	end

endmodule

/* rtl/core/blx_tokq.sv */
module blx_tokq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_cnt,
	input  blx_pkg::blx_out_t push0,
	input  blx_pkg::blx_out_t push1,
	input  logic              out_ready,
	output logic              out_valid,
	output blx_pkg::blx_out_t out_data,
	output logic              room
);
	import blx_pkg::*;

	blx_out_t         mem_q [TQ_DEPTH];
	logic [TQ_AW-1:0] wr_q, rd_q;
	logic [TQ_CW-1:0] cnt_q;
	logic             pop;

	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	// two free entries needed: one character can yield two tokens
	assign room      = (cnt_q <= TQ_CW'(TQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) mem_q[wr_q] <= push0;
		if (push_cnt == 2'd2) mem_q[TQ_AW'(wr_q + 1'b1)] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= TQ_AW'(wr_q + push_cnt);
			if (pop) rd_q <= TQ_AW'(rd_q + 1'b1);
			cnt_q <= TQ_CW'(cnt_q + TQ_CW'(push_cnt) - TQ_CW'(pop));
		end
	end

endmodule

/* rtl/core/basic_language_lexer_top.sv */
// Streaming lexer for a small BASIC-like language. Feed one source byte per
// transaction on src (or a transaction with end_of_input set); tokens come out
// on tok, one per transaction, in source order, with last marking the final
// token caused by a given input transaction. A character is accepted in any
// cycle in which the output queue has two free entries, so the input side
// runs at one character per clock; its tokens enter the queue at the edge
// that accepts it. The sustained rate is set by the tok port, which moves
// one token per clock while tok_ready is high: characters that close a
// pending token and produce a second one (for example "x+") queue two
// tokens, and the four-entry token queue absorbs such bursts. Line numbers
// start at 1, saturate at 65535 and restart with the scan after every end mark.
module basic_language_lexer_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_ready,
	input  blx_pkg::blx_in_t  src,
	output logic              tok_valid,
	input  logic              tok_ready,
	output blx_pkg::blx_out_t tok
);
	import blx_pkg::*;

	scan_res_t  res;
	logic       step;
	logic [1:0] push_cnt;

	// A transaction on src advances the scanner state in the same edge that
	// writes its tokens into the queue.
	assign step     = src_valid && src_ready;
	assign push_cnt = step ? res.count : 2'd0;

	// Character classification, pending-token flush and state update
	blx_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.src    (src),
		.res    (res)
	);

	// Token queue: takes up to two tokens a cycle while it has room, hands out one while tok_ready is high
	blx_tokq u_tokq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push0     (res.t0),
		.push1     (res.t1),
		.out_ready (tok_ready),
		.out_valid (tok_valid),
		.out_data  (tok),
		.room      (src_ready)
	);

endmodule

/* rtl/core/blx_checker.sv */
module blx_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              src_valid,
	input logic              src_ready,
	input blx_pkg::blx_in_t  src,
	input logic              tok_valid,
	input logic              tok_ready,
	input blx_pkg::blx_out_t tok
);
	import blx_pkg::*;

	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid && $stable(tok))
		else $error("tok changed while stalled");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok.token_kind == KIND_END |-> tok.last)
		else $error("end token not last");

	a_relop_only: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok.token_kind != KIND_RELOP |-> tok.relop_kind == '0)
		else $error("relop code on non-relop token");

	a_trunc_len: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok.ident_truncated |->
		tok.ident_length == MAX_ID_CHARS && tok.token_kind == KIND_ID)
		else $error("truncated identifier with short length");

	a_line_nz: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> tok.line_number != '0)
		else $error("line number zero");

endmodule

bind basic_language_lexer_top blx_checker u_blx_checker (.*);

/* dv/tb_basic_language_lexer_top.sv */
`timescale 1ns / 1ps

module tb_basic_language_lexer_top;
	import blx_pkg::*;

	// Cycle budget: about 1650 characters in all. At worst each character
	// waits out a sender gap and two tokens each wait out a tok_ready stall,
	// so the whole run stays well under this.
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 1600;
	localparam int PHASE_ITEMS  = 150;
	localparam int CALM_ITEMS   = 200;
	localparam int DRAIN_CYCLES = 8;

	localparam string OPERATORS  = "+-*/();:";
	localparam string BLANKS     = " \t\n";
	// letters and '_' first (0..52), then digits (53..62)
	localparam string NAME_CHARS =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

	string KEYWORDS[5]  = '{"input", "let", "print", "goto", "if"};
	string RELATIONS[7] = '{"<", "<=", "<>", ">", ">=", "=", "=="};
	int    GAP_PLAN[8]  = '{20, 0, 45, 5, 0, 60, 15, 30};

	logic     clk;
	logic     arst_n;
	logic     src_valid;
	logic     src_ready;
	blx_in_t  src;
	logic     tok_valid;
	logic     tok_ready;
	blx_out_t tok;

	int src_gap_pct = 0;
	int tok_gap_pct = 0;
	int items_sent  = 0;
	int cycle_count = 0;

	basic_language_lexer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src       (src),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok       (tok)
	);

	// Tracks the scanner state on the character side and turns every accepted
	// character transaction into the tokens it must produce. Token
	// transactions are then matched in order against that list.
	class token_tracker;
		blx_out_t    tokens_due[$];
		blx_out_t    step_tokens[$];
		int          errors;
		scan_mode_t  mode;
		logic [30:0] num_acc;
		logic        num_sat;
		logic [63:0] id_buf;
		logic [3:0]  id_cnt;
		logic        id_long;
		logic [15:0] line_no;
		logic [4:0]  prev_kind;

		function new();
			errors = 0;
			restart();
		endfunction

		// also the state after an end mark, apart from the held token text
		function void restart();
			mode      = MODE_IDLE;
			num_acc   = '0;
			num_sat   = 1'b0;
			id_buf    = '0;
			id_cnt    = '0;
			id_long   = 1'b0;
			line_no   = 16'd1;
			prev_kind = KIND_START;
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit is_name_start(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
		endfunction

		function blx_out_t plain_token(logic [4:0] kind);
			blx_out_t t;
			t = '0;
			t.token_kind  = kind;
			t.line_number = line_no;
			return t;
		endfunction

		function blx_out_t relation_token(logic [2:0] rel);
			blx_out_t t;
			t = plain_token(KIND_RELOP);
			t.relop_kind = rel;
			return t;
		endfunction

		function void add_token(blx_out_t t);
			step_tokens.push_back(t);
			prev_kind = t.token_kind;
		endfunction

		// exact, case-sensitive match; a truncated name never matches
		function logic [4:0] name_kind();
			if (id_long)
				return KIND_ID;
			if (id_buf == KW_INPUT)
				return KIND_INPUT;
			if (id_buf == KW_LET)
				return KIND_LET;
			if (id_buf == KW_PRINT)
				return KIND_PRINT;
			if (id_buf == KW_GOTO)
				return KIND_GOTO;
			if (id_buf == KW_IF)
				return KIND_IF;
			return KIND_ID;
		endfunction

		// close whatever token is open
		function void close_pending();
			blx_out_t   t;
			logic [4:0] kind;
			unique case (mode)
				MODE_NUM: begin
					t = plain_token(KIND_NUM);
					t.number_value    = num_acc;
					t.number_overflow = num_sat;
					add_token(t);
				end
				MODE_ID: begin
					kind = name_kind();
					t = plain_token(kind);
					if (kind == KIND_ID) begin
						t.ident_chars     = id_buf;
						t.ident_length    = id_cnt;
						t.ident_truncated = id_long;
					end
					add_token(t);
				end
				MODE_LT: add_token(relation_token(REL_LT));
				MODE_GT: add_token(relation_token(REL_GT));
				MODE_EQ: add_token(plain_token(KIND_ASSIGN));
				default: ;
			endcase
			mode = MODE_IDLE;
		endfunction

		function void scan_idle(logic [7:0] c);
			bit unary;
			unary = prev_kind inside {KIND_PLUS, KIND_MINUS, KIND_UMINUS, KIND_MUL,
				KIND_DIV, KIND_ASSIGN, KIND_LPAREN, KIND_RELOP, KIND_START};
			if (c == " " || c == "\t" || c == "\n") begin
				if (c == "\n" && line_no != LINE_MAX)
					line_no++;
			end else if (is_digit(c)) begin
				mode    = MODE_NUM;
				num_acc = 31'(c[3:0]);
				num_sat = 1'b0;
			end else if (is_name_start(c)) begin
				mode    = MODE_ID;
				id_buf  = 64'(c);
				id_cnt  = 4'd1;
				id_long = 1'b0;
			end else begin
				unique case (c)
					"<": mode = MODE_LT;
					">": mode = MODE_GT;
					"=": mode = MODE_EQ;
					"+": add_token(plain_token(KIND_PLUS));
					"-": add_token(plain_token(unary ? KIND_UMINUS : KIND_MINUS));
					"*": add_token(plain_token(KIND_MUL));
					"/": add_token(plain_token(KIND_DIV));
					"(": add_token(plain_token(KIND_LPAREN));
					")": add_token(plain_token(KIND_RPAREN));
					";": add_token(plain_token(KIND_SEMI));
					":": add_token(plain_token(KIND_COLON));
					default: ; // unknown byte, dropped
				endcase
			end
		endfunction

		function void scan_char(blx_in_t item);
			logic [7:0]  c;
			logic [63:0] grown;
			c = item.ch;
			step_tokens.delete();
			if (item.end_of_input) begin
				close_pending();
				add_token(plain_token(KIND_END));
				restart();
			end else begin
				unique case (mode)
					MODE_NUM: begin
						if (is_digit(c)) begin
							grown = 64'(num_acc) * 64'd10 + 64'(c[3:0]);
							if (grown > 64'(NUM_MAX)) begin
								num_acc = NUM_MAX;
								num_sat = 1'b1;
							end else begin
								num_acc = grown[30:0];
							end
						end else begin
							close_pending();
							scan_idle(c);
						end
					end
					MODE_ID: begin
						if (is_name_start(c) || is_digit(c)) begin
							if (id_cnt < MAX_ID_CHARS) begin
								id_buf = id_buf | (64'(c) << (8 * id_cnt));
								id_cnt++;
							end else begin
								id_long = 1'b1;
							end
						end else begin
							close_pending();
							scan_idle(c);
						end
					end
					MODE_LT: begin
						if (c == ">") begin
							add_token(relation_token(REL_NE));
							mode = MODE_IDLE;
						end else if (c == "=") begin
							add_token(relation_token(REL_LE));
							mode = MODE_IDLE;
						end else begin
							close_pending();
							scan_idle(c);
						end
					end
					MODE_GT: begin
						if (c == "=") begin
							add_token(relation_token(REL_GE));
							mode = MODE_IDLE;
						end else begin
							close_pending();
							scan_idle(c);
						end
					end
					MODE_EQ: begin
						if (c == "=") begin
							add_token(relation_token(REL_EQ));
							mode = MODE_IDLE;
						end else begin
							close_pending();
							scan_idle(c);
						end
					end
					default: begin
						mode = MODE_IDLE;
						scan_idle(c);
					end
				endcase
			end
			if (step_tokens.size() != 0)
				step_tokens[step_tokens.size() - 1].last = 1'b1;
			foreach (step_tokens[i])
				tokens_due.push_back(step_tokens[i]);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t: token %s mismatch: expected %0h, actual %0h",
					$time, name, want, got);
				errors++;
			end
		endfunction

		function void match_token(blx_out_t got);
			blx_out_t want;
			if (tokens_due.size() == 0) begin
				$display("%0t: unexpected token: expected none, actual kind %0d",
					$time, got.token_kind);
				errors++;
				return;
			end
			want = tokens_due.pop_front();
			compare_field("token_kind", want.token_kind, got.token_kind);
			compare_field("relop_kind", want.relop_kind, got.relop_kind);
			compare_field("number_value", want.number_value, got.number_value);
			compare_field("number_overflow", want.number_overflow, got.number_overflow);
			compare_field("ident_chars", want.ident_chars, got.ident_chars);
			compare_field("ident_length", want.ident_length, got.ident_length);
			compare_field("ident_truncated", want.ident_truncated, got.ident_truncated);
			compare_field("line_number", want.line_number, got.line_number);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	token_tracker sb = new();

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles, %0d tokens outstanding",
			$time, cycle_count, sb.tokens_due.size());
		$display("status: fail");
		$finish;
	end

	// Token side: check every accepted transaction, then choose tok_ready for
	// the next cycle. Stalls come in bursts.
	initial begin : token_sink
		int stall_left;
		stall_left = 0;
		tok_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (tok_valid && tok_ready)
				sb.match_token(tok);
			if (stall_left > 0) begin
				stall_left--;
				tok_ready <= 1'b0;
			end else if (tok_gap_pct != 0 && $urandom_range(0, 399) < tok_gap_pct) begin
				stall_left = $urandom_range(0, 14);
				tok_ready <= 1'b0;
			end else begin
				tok_ready <= 1'b1;
			end
		end
	end

	// One character transaction. Entered at a rising edge; returns at the edge
	// where it was accepted, so the next call can keep src_valid high.
	task automatic send_item(blx_in_t item);
		int gap;
		if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
			gap = $urandom_range(1, 15);
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src       <= item;
		@(posedge clk);
		while (!src_ready)
			@(posedge clk);
		sb.scan_char(item);
		items_sent++;
	endtask

	task automatic send_char(logic [7:0] c);
		send_item('{ch: c, end_of_input: 1'b0});
	endtask

	task automatic send_end(logic [7:0] c);
		send_item('{ch: c, end_of_input: 1'b1});
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	function automatic logic [7:0] name_char(bit with_digits);
		return NAME_CHARS[$urandom_range(0, with_digits ? 62 : 52)];
	endfunction

	// One lexeme of the language, mostly well formed: numbers (some long
	// enough to saturate), names and keywords (some with a flipped case or a
	// tail), operators, relations, blanks, stray bytes and end marks. About
	// half of the lexemes abut the next one so that one character both
	// closes a token and starts or emits another.
	task automatic send_lexeme();
		logic [7:0] text[$];
		int         pick;
		int         n;
		int         pos;
		string      word;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			n = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 4);
			repeat (n)
				text.push_back(8'h30 + 8'($urandom_range(0, 9)));
		end else if (pick < 40) begin
			if ($urandom_range(0, 2) == 0) begin
				word = KEYWORDS[$urandom_range(0, 4)];
				for (int i = 0; i < word.len(); i++)
					text.push_back(word[i]);
				if ($urandom_range(0, 4) == 0) begin
					pos = $urandom_range(0, text.size() - 1);
					text[pos] = text[pos] ^ 8'h20;
				end
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 6))
						text.push_back(name_char(1'b1));
			end else begin
				n = $urandom_range(1, 12);
				text.push_back(name_char(1'b0));
				repeat (n - 1)
					text.push_back(name_char(1'b1));
			end
		end else if (pick < 65) begin
			text.push_back(OPERATORS[$urandom_range(0, OPERATORS.len() - 1)]);
		end else if (pick < 80) begin
			word = RELATIONS[$urandom_range(0, 6)];
			for (int i = 0; i < word.len(); i++)
				text.push_back(word[i]);
		end else if (pick < 92) begin
			text.push_back(BLANKS[$urandom_range(0, 2)]);
		end else if (pick < 97) begin
			text.push_back(8'($urandom_range(0, 255)));
		end else begin
			send_end(8'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 9) < 4)
			text.push_back(BLANKS[$urandom_range(0, 2)]);
		foreach (text[i])
			send_char(text[i]);
	endtask

	initial begin : stimulus
		int random_start;
		int done;
		arst_n    <= 1'b0;
		src_valid <= 1'b0;
		src       <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: minus at the start of a source and after '(' is unary;
		// keywords are case sensitive; a stray high byte closes a lone '<';
		// a ten-digit number saturates; end flushes a lone '=' and ignores ch;
		// an eight-character name holds exactly eight bytes; end after '>'.
		src_gap_pct = 10;
		tok_gap_pct = 10;
		send_text("-(-Let<");
		send_char(8'hFF);
		send_text("9999999999=");
		send_end(8'h00);
		send_text("ifprint1>");
		send_end(8'hFF);

		// Newlines advance the line count, and an end mark brings it back to 1.
		src_gap_pct = 0;
		tok_gap_pct = 0;
		repeat (5)
			send_char("\n");
		send_text("x;");
		send_end(8'h5A);
		send_text("y;");

		// Random source text. The idling plan changes every 150 character
		// transactions; the closing stretch runs with no idling at all.
		random_start = items_sent;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			if (done > RANDOM_ITEMS - CALM_ITEMS) begin
				src_gap_pct = 0;
				tok_gap_pct = 0;
			end else begin
				src_gap_pct = GAP_PLAN[(done / PHASE_ITEMS) % 8];
				tok_gap_pct = GAP_PLAN[(done / PHASE_ITEMS + 3) % 8];
			end
			send_lexeme();
			done = items_sent - random_start;
		end
		send_end(8'($urandom_range(0, 255)));
		src_valid <= 1'b0;

		while (sb.tokens_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.tokens_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/blx_pkg.sv
rtl/core/blx_scan.sv
rtl/core/blx_tokq.sv
rtl/core/basic_language_lexer_top.sv
rtl/core/blx_checker.sv
dv/tb_basic_language_lexer_top.sv
